// ----- rtl/core/kvt_pkg.sv -----
// Shared types and codes for the key-value array table.
`default_nettype none

package kvt_pkg;

  // Operation codes carried in the kind field
  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_ERASE = 2'd2,
    KIND_CLEAR = 2'd3
  } kvt_kind_e;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_ABSENT = 2'd1,
    STATUS_FULL   = 2'd2
  } kvt_status_e;

  // Request transaction payload
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] key;
    logic [31:0] value;
  } kvt_in_t;

  // Response transaction payload
  typedef struct packed {
    logic [31:0] read_value;
    logic        found;
    logic [1:0]  status;
    logic [4:0]  entry_count;
  } kvt_out_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic lookup;     // compare the broadcast key and latch the hit flag
    logic write_hit;  // overwrite the value of the hit cell
    logic append;     // load the new entry into the cell at the fill position
    logic erase;      // take the neighbor's entry from the hit position upward
  } kvt_cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/key_value_array_table_unit.sv -----
// Top level of the key-value array table: sequencer, cell chain and response register.
`default_nettype none

// Key-value table of up to CAPACITY distinct keys, kept packed in insertion
// order in a row of cells. Each transaction has an accept cycle and an apply
// cycle: in the accept cycle every cell compares its key with the request key at
// once and latches a hit flag; in the apply cycle that follows, the hit is
// resolved, the entry is updated, appended or erased, or the table cleared (cells
// at and above the hit position take their upper neighbor's entry together) and
// the response is registered. The next request is accepted in the cycle after
// the apply cycle, so a new request is not taken while one is in progress. The
// apply cycle waits while an earlier response is still held and not taken. Reads
// and writes return the value held before the operation; a write of a new key
// into a full table returns the full status, an erase of an absent key the
// absent status. entry_count gives the low five bits of the fill count.
module key_value_array_table_unit #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire kvt_pkg::kvt_in_t in_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output kvt_pkg::kvt_out_t    out_o
);

  localparam int unsigned CNT_BITS = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CNT_BITS-1:0] CapCnt = CNT_BITS'(CAPACITY);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_APPLY = 2'b10
  } kvt_state_e;

  kvt_state_e state_q, state_d;

  logic [CNT_BITS-1:0]   count_q, count_d;
  logic [1:0]            kind_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;

  logic [KEY_BITS-1:0]   in_key;
  logic [VALUE_BITS-1:0] in_value;
  logic [KEY_BITS-1:0]   bus_key;
  logic [VALUE_BITS-1:0] bus_value;

  logic                  accept;
  logic                  advance;
  kvt_pkg::kvt_cell_ctrl_t cell_ctrl;

  logic [KEY_BITS-1:0]   cell_key   [CAPACITY];
  logic [VALUE_BITS-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]   hit_vec;

  logic                  found;
  logic [IDX_BITS-1:0]   hit_idx;
  logic [VALUE_BITS-1:0] hit_value;

  logic [VALUE_BITS-1:0] rsp_value;
  kvt_pkg::kvt_status_e  rsp_status;
  logic [31:0]           rsp_value_32;
  logic [4:0]            rsp_count_5;

  kvt_pkg::kvt_out_t     out_q, out_d;
  logic                  out_valid_q, out_valid_d;

  // Resize request fields to the stored widths, and the response value and count to the response widths
  if (KEY_BITS <= 32) begin : g_key_trunc
    assign in_key = in_i.key[KEY_BITS-1:0];
  end else begin : g_key_ext
    assign in_key = {{(KEY_BITS-32){1'b0}}, in_i.key};
  end

  if (VALUE_BITS <= 32) begin : g_val_trunc
    assign in_value     = in_i.value[VALUE_BITS-1:0];
    assign rsp_value_32 = 32'(rsp_value);
  end else begin : g_val_ext
    assign in_value     = {{(VALUE_BITS-32){1'b0}}, in_i.value};
    assign rsp_value_32 = rsp_value[31:0];
  end

  if (CNT_BITS >= 5) begin : g_cnt_trunc
    assign rsp_count_5 = count_d[4:0];
  end else begin : g_cnt_ext
    assign rsp_count_5 = {{(5-CNT_BITS){1'b0}}, count_d};
  end

  // Handshakes
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign advance    = (state_q == ST_APPLY) && (!out_valid_q || out_ready_i);

  // Key bus carries the request key while comparing, the held key while applying
  assign bus_key   = (state_q == ST_IDLE) ? in_key : key_q;
  assign bus_value = value_q;

  // Hold the accepted request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= in_i.kind;
      key_q   <= in_key;
      value_q <= in_value;
    end
  end

  // Resolve the one-hot hit vector
  always_comb begin
    found     = |hit_vec;
    hit_idx   = '0;
    hit_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_idx   = hit_idx | ({IDX_BITS{hit_vec[i]}} & IDX_BITS'(i));
      hit_value = hit_value | ({VALUE_BITS{hit_vec[i]}} & cell_value[i]);
    end
  end

  // Decode the operation in the apply cycle
  always_comb begin
    cell_ctrl        = '0;
    cell_ctrl.lookup = accept;
    count_d          = count_q;
    rsp_value        = '0;
    rsp_status       = kvt_pkg::STATUS_OK;
    case (kvt_pkg::kvt_kind_e'(kind_q))
      kvt_pkg::KIND_READ: begin
        if (found) rsp_value = hit_value;
      end
      kvt_pkg::KIND_WRITE: begin
        if (found) begin
          rsp_value           = hit_value;
          cell_ctrl.write_hit = advance;
        end else if (count_q < CapCnt) begin
          cell_ctrl.append = advance;
          count_d          = count_q + 1'b1;
        end else begin
          rsp_status = kvt_pkg::STATUS_FULL;
        end
      end
      kvt_pkg::KIND_ERASE: begin
        if (found) begin
          cell_ctrl.erase = advance;
          count_d         = count_q - 1'b1;
        end else begin
          rsp_status = kvt_pkg::STATUS_ABSENT;
        end
      end
      kvt_pkg::KIND_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  // Build the response
  always_comb begin
    out_d             = out_q;
    out_valid_d       = out_valid_q && !out_ready_i;
    if (advance) begin
      out_d.read_value  = rsp_value_32;
      out_d.found       = found && (kind_q != kvt_pkg::KIND_CLEAR);
      out_d.status      = rsp_status;
      out_d.entry_count = rsp_count_5;
      out_valid_d       = 1'b1;
    end
  end

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept)  state_d = ST_APPLY;
      ST_APPLY: if (advance) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (advance) count_q <= count_d;
    end
  end

  // Response payload register
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Chain of cells; the top cell holds its own entry on a shift
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [KEY_BITS-1:0]   nxt_key;
    logic [VALUE_BITS-1:0] nxt_value;

    if (g == CAPACITY - 1) begin : g_top
      assign nxt_key   = cell_key[g];
      assign nxt_value = cell_value[g];
    end else begin : g_mid
      assign nxt_key   = cell_key[g+1];
      assign nxt_value = cell_value[g+1];
    end

    kvt_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .CNT_BITS   (CNT_BITS),
      .IDX_BITS   (IDX_BITS),
      .INDEX      (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .key_i        (bus_key),
      .value_i      (bus_value),
      .count_i      (count_q),
      .hit_idx_i    (hit_idx),
      .next_key_i   (nxt_key),
      .next_value_i (nxt_value),
      .key_o        (cell_key[g]),
      .value_o      (cell_value[g]),
      .hit_o        (hit_vec[g])
    );
  end

`ifndef SYNTH
  // Fill count never passes the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCnt)
    else $error("fill count above capacity");

  // Keys are distinct, so at most one cell hits
  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_APPLY) |-> $onehot0(hit_vec))
    else $error("more than one cell hit");

  // An accepted transaction moves straight to the apply cycle
  a_accept_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_APPLY))
    else $error("accept did not enter apply");

  // A full status is only reported when the table is full
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status == kvt_pkg::STATUS_FULL)) |-> (count_q == CapCnt))
    else $error("full status with free entries");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/kvt_cell.sv -----
// One table cell: holds a key/value entry, compares, and shifts down on erase.
`default_nettype none

module kvt_cell #(
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned CNT_BITS   = 5,
  parameter int unsigned IDX_BITS   = 4,
  parameter int unsigned INDEX      = 0
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire kvt_pkg::kvt_cell_ctrl_t ctrl_i,
  input  wire  [KEY_BITS-1:0]         key_i,
  input  wire  [VALUE_BITS-1:0]       value_i,
  input  wire  [CNT_BITS-1:0]         count_i,
  input  wire  [IDX_BITS-1:0]         hit_idx_i,
  input  wire  [KEY_BITS-1:0]         next_key_i,
  input  wire  [VALUE_BITS-1:0]       next_value_i,
  output logic [KEY_BITS-1:0]         key_o,
  output logic [VALUE_BITS-1:0]       value_o,
  output logic                        hit_o
);

  localparam logic [CNT_BITS-1:0] MyCnt = CNT_BITS'(INDEX);
  localparam logic [IDX_BITS-1:0] MyIdx = IDX_BITS'(INDEX);

  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic                  hit_q;
  logic                  hit_d;
  logic                  cell_valid;

  // Entry is live while it sits below the fill count
  assign cell_valid = (count_i > MyCnt);
  assign hit_d      = ctrl_i.lookup ? (cell_valid && (key_q == key_i)) : hit_q;

  // Latch the compare result of the accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  // Update the entry: overwrite, append, or take the neighbor's entry
  always_ff @(posedge clk_i) begin
    if (ctrl_i.write_hit && hit_q) begin
      value_q <= value_i;
    end else if (ctrl_i.append && (count_i == MyCnt)) begin
      key_q   <= key_i;
      value_q <= value_i;
    end else if (ctrl_i.erase && (MyIdx >= hit_idx_i)) begin
      key_q   <= next_key_i;
      value_q <= next_value_i;
    end
  end

  assign key_o   = key_q;
  assign value_o = value_q;
  assign hit_o   = hit_q;

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the key-value array table unit.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kvt_pkg::*;

  localparam int unsigned CAPACITY       = 16;
  localparam int          RANDOM_OPS     = 2000;
  localparam int          STALL_PCT      = 9;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          DRAIN_CYCLES   = 8;
  localparam int          POOL_MAX       = 24;

  // One row of the directed sequence; typed rows carry their response
  typedef struct packed {
    kvt_in_t  req;
    logic     typed;
    kvt_out_t resp;
  } directed_row_t;

  localparam int DIRECTED_COUNT = 26;
  localparam directed_row_t DIRECTED_OPS [DIRECTED_COUNT] = '{
    // empty table: read miss, erase miss
    '{'{KIND_READ,  32'h0000_0000, 32'h0000_0000}, 1'b1, '{32'h0, 1'b0, STATUS_OK, 5'd0}},
    '{'{KIND_ERASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, '{32'h0, 1'b0, STATUS_ABSENT, 5'd0}},
    // extreme keys and values, then a hit and an update
    '{'{KIND_WRITE, 32'h0000_0000, 32'hFFFF_FFFF}, 1'b1, '{32'h0, 1'b0, STATUS_OK, 5'd1}},
    '{'{KIND_WRITE, 32'hFFFF_FFFF, 32'h0000_0000}, 1'b1, '{32'h0, 1'b0, STATUS_OK, 5'd2}},
    '{'{KIND_READ,  32'h0000_0000, 32'h1234_5678}, 1'b1,
      '{32'hFFFF_FFFF, 1'b1, STATUS_OK, 5'd2}},
    '{'{KIND_WRITE, 32'h0000_0000, 32'h5A5A_A5A5}, 1'b1,
      '{32'hFFFF_FFFF, 1'b1, STATUS_OK, 5'd2}},
    // fill to capacity
    '{'{KIND_WRITE, 32'h0000_0001, 32'h8000_0001}, 1'b0, '0},
    '{'{KIND_WRITE, 32'h0000_0002, 32'h8000_0002}, 1'b0, '0},
    '{'{KIND_WRITE, 32'h0000_0004, 32'h8000_0004}, 1'b0, '0},
    '{'{KIND_WRITE, 32'h0000_0008, 32'h8000_0008}, 1'b0, '0},
    '{'{KIND_WRITE, 32'h0000_0010, 32'h8000_0010}, 1'b0, '0},
    '{'{KIND_WRITE, 32'h0000_0020, 32'h8000_0020}, 1'b0, '0},
    '{'{KIND_WRITE, 32'h0000_0040, 32'h8000_0040}, 1'b0, '0},
    '{'{KIND_WRITE, 32'h0000_0080, 32'h8000_0080}, 1'b0, '0},
    '{'{KIND_WRITE, 32'h0000_0100, 32'h8000_0100}, 1'b0, '0},
    '{'{KIND_WRITE, 32'h0000_0200, 32'h8000_0200}, 1'b0, '0},
    '{'{KIND_WRITE, 32'h0000_0400, 32'h8000_0400}, 1'b0, '0},
    '{'{KIND_WRITE, 32'h0000_0800, 32'h8000_0800}, 1'b0, '0},
    '{'{KIND_WRITE, 32'h0000_1000, 32'h8000_1000}, 1'b0, '0},
    '{'{KIND_WRITE, 32'h0000_2000, 32'h8000_2000}, 1'b0, '0},
    // new key refused when full, existing key still updates
    '{'{KIND_WRITE, 32'h7FFF_FFFF, 32'h0000_0001}, 1'b1, '{32'h0, 1'b0, STATUS_FULL, 5'd16}},
    '{'{KIND_WRITE, 32'h0000_0000, 32'h0000_0000}, 1'b0, '0},
    // erase the first entry (full shift) and the last entry
    '{'{KIND_ERASE, 32'h0000_0000, 32'h0000_0000}, 1'b0, '0},
    '{'{KIND_ERASE, 32'h0000_2000, 32'h0000_0000}, 1'b0, '0},
    // clear, then a miss on an old key
    '{'{KIND_CLEAR, 32'h0000_0001, 32'hFFFF_FFFF}, 1'b1, '{32'h0, 1'b0, STATUS_OK, 5'd0}},
    '{'{KIND_READ,  32'hFFFF_FFFF, 32'h0000_0000}, 1'b1, '{32'h0, 1'b0, STATUS_OK, 5'd0}}
  };

  logic     clk_i;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  kvt_in_t  in_req      = '0;
  logic     out_ready_i = 1'b0;
  logic     in_ready_o;
  logic     out_valid_o;
  kvt_out_t out_resp;

  // Predicted table contents, in insertion order
  logic [31:0] table_keys   [CAPACITY];
  logic [31:0] table_values [CAPACITY];
  int          table_fill = 0;

  kvt_out_t pending_responses [$];
  int       error_count = 0;
  int       idle_cycles = 0;
  logic     steady_stretch = 1'b0;

  // Operation tallies for the summary
  int ops_by_kind [4] = '{0, 0, 0, 0};
  int hit_count       = 0;
  int full_refusals   = 0;
  int absent_erases   = 0;

  key_value_array_table_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_req),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_resp)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Apply one operation to the predicted table and return its response
  function automatic kvt_out_t apply_table_op(input kvt_in_t req);
    kvt_out_t resp;
    int       hit;
    resp = '0;
    hit  = -1;
    if (req.kind == KIND_CLEAR) begin
      table_fill = 0;
    end else begin
      for (int i = 0; i < table_fill; i++) begin
        if (hit < 0 && table_keys[i] == req.key) hit = i;
      end
      resp.found = (hit >= 0);
      case (req.kind)
        KIND_READ: begin
          if (hit >= 0) resp.read_value = table_values[hit];
        end
        KIND_WRITE: begin
          if (hit >= 0) begin
            resp.read_value   = table_values[hit];
            table_values[hit] = req.value;
          end else if (table_fill < CAPACITY) begin
            table_keys[table_fill]   = req.key;
            table_values[table_fill] = req.value;
            table_fill++;
          end else begin
            resp.status = STATUS_FULL;
          end
        end
        default: begin
          if (hit >= 0) begin
            // close the gap left by the erased entry
            for (int i = hit; i < table_fill - 1; i++) begin
              table_keys[i]   = table_keys[i + 1];
              table_values[i] = table_values[i + 1];
            end
            table_fill--;
          end else begin
            resp.status = STATUS_ABSENT;
          end
        end
      endcase
    end
    resp.entry_count = 5'(table_fill);
    return resp;
  endfunction

  // Present one request, hold it until accepted, then queue its response
  task automatic issue_request(input kvt_in_t req, input logic typed, input kvt_out_t typed_resp);
    kvt_out_t predicted;
    while (!steady_stretch && $urandom_range(99) < STALL_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req     <= req;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = apply_table_op(req);
    pending_responses.push_back(typed ? typed_resp : predicted);
    ops_by_kind[req.kind]++;
    if (predicted.found) hit_count++;
    if (predicted.status == STATUS_FULL) full_refusals++;
    if (predicted.status == STATUS_ABSENT) absent_erases++;
  endtask

  task automatic flag_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
    error_count++;
  endtask

  // Check each response transaction against the oldest prediction; stall at random
  always @(posedge clk_i) begin : response_check
    kvt_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_responses.size() == 0) begin
        $error("response with no request outstanding: 0x%0h", out_resp);
        error_count++;
      end else begin
        want = pending_responses.pop_front();
        if (out_resp.read_value !== want.read_value)
          flag_mismatch("read_value", want.read_value, out_resp.read_value);
        if (out_resp.found !== want.found)
          flag_mismatch("found", 32'(want.found), 32'(out_resp.found));
        if (out_resp.status !== want.status)
          flag_mismatch("status", 32'(want.status), 32'(out_resp.status));
        if (out_resp.entry_count !== want.entry_count)
          flag_mismatch("entry_count", 32'(want.entry_count), 32'(out_resp.entry_count));
      end
    end
    out_ready_i <= steady_stretch || ($urandom_range(99) >= STALL_PCT);
  end

  // End the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [31:0] key_pool [POOL_MAX];
    int          pool_size;
    int          write_pct;
    int          erase_pct;
    int          roll;
    kvt_in_t     req;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed sequence
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      issue_request(DIRECTED_OPS[i].req, DIRECTED_OPS[i].typed, DIRECTED_OPS[i].resp);
    end

    // Random sequence in segments, each with its own key pool and operation mix
    pool_size = 2;
    write_pct = 40;
    erase_pct = 25;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 100 == 0) begin
        pool_size = $urandom_range(POOL_MAX, 2);
        for (int p = 0; p < POOL_MAX; p++) begin
          roll = $urandom_range(9);
          if (roll == 0) key_pool[p] = 32'h1 << $urandom_range(31);
          else if (roll == 1) key_pool[p] = ~(32'h1 << $urandom_range(31));
          else if (roll == 2) key_pool[p] = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
          else key_pool[p] = $urandom();
        end
        case ($urandom_range(2))
          0: begin write_pct = 60; erase_pct = 10; end  // fill
          1: begin write_pct = 20; erase_pct = 50; end  // drain
          default: begin write_pct = 40; erase_pct = 25; end
        endcase
      end
      // no idling on either side through one long stretch
      steady_stretch <= (n >= 1000 && n < 1300);

      roll = $urandom_range(99);
      if (roll < 1) req.kind = KIND_CLEAR;
      else if (roll < write_pct) req.kind = KIND_WRITE;
      else if (roll < write_pct + erase_pct) req.kind = KIND_ERASE;
      else req.kind = KIND_READ;

      // mostly pool keys, some one-bit neighbors of pool keys, some noise
      roll = $urandom_range(99);
      if (roll < 80) req.key = key_pool[$urandom_range(pool_size - 1)];
      else if (roll < 90)
        req.key = key_pool[$urandom_range(pool_size - 1)] ^ (32'h1 << $urandom_range(31));
      else req.key = $urandom();

      roll = $urandom_range(99);
      if (roll < 5) req.value = 32'h0;
      else if (roll < 10) req.value = 32'hFFFF_FFFF;
      else req.value = $urandom();

      issue_request(req, 1'b0, '0);
    end
    in_valid_i     <= 1'b0;
    steady_stretch <= 1'b0;

    // Drain outstanding responses, then watch for strays
    while (pending_responses.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d operations: %0d reads, %0d writes, %0d erases, %0d clears",
             DIRECTED_COUNT + RANDOM_OPS, ops_by_kind[KIND_READ], ops_by_kind[KIND_WRITE],
             ops_by_kind[KIND_ERASE], ops_by_kind[KIND_CLEAR]);
    $display("Key hits %0d, inserts refused on full table %0d, erases of absent keys %0d",
             hit_count, full_refusals, absent_erases);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/core/kvt_pkg.sv
rtl/core/kvt_cell.sv
rtl/core/key_value_array_table_unit.sv
tb/sv/tb.sv
